// ===== design/cidw_pkg.sv =====
// Shared types and constants for the card ID whitelist table.
package cidw_pkg;

    localparam int STORE_DEPTH     = 63;
    localparam int DEF_MAX_ENTRIES = 63;
    localparam int IDX_W           = 6;
    localparam int ID_W            = 32;
    localparam int OP_W            = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CHECK  = 3'd0,
        OP_SAVE   = 3'd1,
        OP_READ   = 3'd2,
        OP_DELETE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_FOUND,
        RES_SAVE,
        RES_READ,
        RES_DEL,
        RES_CLEAR
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     scan_start;
        logic     scan_step;
        logic     rd_issue;
        logic     shift_start;
        logic     shift_step;
        logic     commit;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            idx_ok;
        logic            hit;
        logic            scan_end;
        logic            out_free;
    } t_dp_sts;

endpackage

// ===== design/cidw_ctrl.sv =====
// Sequencing state machine for the card ID whitelist table.
module cidw_ctrl
    import cidw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state   r_state, n_state;
    t_res_sel r_res_sel, n_res_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_res_sel <= RES_ZERO;
        end else begin
            r_state   <= n_state;
            r_res_sel <= n_res_sel;
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_res_sel = r_res_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state   = S_FINISH;
                n_res_sel = RES_ZERO;
                case (i_sts.op)
                    OP_CHECK: begin
                        n_state = S_SCAN;
                    end
                    OP_SAVE: begin
                        if (!i_sts.full) begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.idx_ok) begin
                            n_res_sel = RES_READ;
                        end
                    end
                    OP_DELETE: begin
                        if (i_sts.idx_ok) begin
                            n_state = S_SHIFT;
                        end
                    end
                    OP_CLEAR: begin
                        n_res_sel = RES_CLEAR;
                    end
                    default: begin
                        n_res_sel = RES_ZERO;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state   = S_FINISH;
                    n_res_sel = (i_sts.op == OP_CHECK) ? RES_FOUND : RES_ZERO;
                end else if (i_sts.scan_end) begin
                    n_state   = S_FINISH;
                    n_res_sel = (i_sts.op == OP_CHECK) ? RES_ZERO : RES_SAVE;
                end
            end
            S_SHIFT: begin
                if (i_sts.scan_end) begin
                    n_state   = S_FINISH;
                    n_res_sel = RES_DEL;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.res_sel = r_res_sel;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_CHECK:  o_cmd.scan_start  = 1'b1;
                    OP_SAVE:   o_cmd.scan_start  = !i_sts.full;
                    OP_READ:   o_cmd.rd_issue    = i_sts.idx_ok;
                    OP_DELETE: o_cmd.shift_start = i_sts.idx_ok;
                    default:   o_cmd.scan_start  = 1'b0;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = !i_sts.hit && !i_sts.scan_end;
            end
            S_SHIFT: begin
                o_cmd.shift_step = !i_sts.scan_end;
            end
            S_FINISH: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_finish_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("finish did not return to idle");

endmodule

// ===== design/cidw_dp.sv =====
// ID store, count, scan pointer and result register for the whitelist table.
module cidw_dp
    import cidw_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [OP_W-1:0]  i_op,
    input  logic [ID_W-1:0]  i_card_id,
    input  logic [IDX_W-1:0] i_entry_index,
    input  logic             i_out_ready,
    output t_dp_sts          o_sts,
    output logic             o_out_valid,
    output logic [IDX_W-1:0] o_result_index,
    output logic [ID_W-1:0]  o_card_id_out,
    output logic [IDX_W-1:0] o_entry_count
);

    localparam int CAP_INT = (MAX_ENTRIES < STORE_DEPTH) ? MAX_ENTRIES : STORE_DEPTH;
    localparam logic [IDX_W-1:0] CAP = IDX_W'(CAP_INT);

    logic [ID_W-1:0]  r_mem [0:STORE_DEPTH-1];

    logic [OP_W-1:0]  r_op;
    logic [ID_W-1:0]  r_key;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic             r_pend, n_pend;
    logic [ID_W-1:0]  r_rd_data;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_res, n_out_res;
    logic [ID_W-1:0]  r_out_id, n_out_id;
    logic [IDX_W-1:0] r_out_cnt;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ID_W-1:0]  wr_data;
    logic             step;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;
    assign step     = i_cmd.scan_step || i_cmd.shift_step;

    assign o_sts.op       = r_op;
    assign o_sts.full     = (r_count >= CAP);
    assign o_sts.idx_ok   = (r_idx != '0) && (r_idx <= r_count);
    assign o_sts.hit      = r_pend && (r_rd_data == r_key);
    assign o_sts.scan_end = !r_pend && (r_ptr >= r_count);
    assign o_sts.out_free = out_free;

    // scan pointer: one read issued per step, compare or move in the next cycle
    always_comb begin
        n_ptr     = r_ptr;
        n_cmp_idx = r_cmp_idx;
        n_pend    = r_pend;
        rd_en     = 1'b0;
        rd_addr   = r_ptr;
        if (i_cmd.scan_start) begin
            n_ptr  = '0;
            n_pend = 1'b0;
        end else if (i_cmd.shift_start) begin
            n_ptr  = r_idx;
            n_pend = 1'b0;
        end else if (i_cmd.rd_issue) begin
            rd_en   = 1'b1;
            rd_addr = r_idx - IDX_W'(1);
        end else if (step) begin
            if (r_ptr < r_count) begin
                rd_en     = 1'b1;
                n_cmp_idx = r_ptr;
                n_ptr     = r_ptr + IDX_W'(1);
                n_pend    = 1'b1;
            end else begin
                n_pend = 1'b0;
            end
        end
    end

    // result and count update on commit; RAM write on a save commit or a shift step
    always_comb begin
        n_count   = r_count;
        n_out_res = '0;
        n_out_id  = '0;
        wr_en     = 1'b0;
        wr_addr   = r_cmp_idx - IDX_W'(1);
        wr_data   = r_rd_data;
        if (i_cmd.shift_step && r_pend) begin
            wr_en = 1'b1;
        end
        if (i_cmd.commit) begin
            case (i_cmd.res_sel)
                RES_FOUND: begin
                    n_out_res = r_cmp_idx + IDX_W'(1);
                end
                RES_SAVE: begin
                    wr_en     = 1'b1;
                    wr_addr   = r_count;
                    wr_data   = r_key;
                    n_count   = r_count + IDX_W'(1);
                    n_out_res = r_count + IDX_W'(1);
                end
                RES_READ: begin
                    n_out_res = r_idx;
                    n_out_id  = r_rd_data;
                end
                RES_DEL: begin
                    n_count   = r_count - IDX_W'(1);
                    n_out_res = r_idx;
                end
                RES_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_out_res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_cmp_idx <= n_cmp_idx;
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_key <= i_card_id;
            r_idx <= i_entry_index;
        end
        if (i_cmd.commit) begin
            r_out_res <= n_out_res;
            r_out_id  <= n_out_id;
            r_out_cnt <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_out_res;
    assign o_card_id_out  = r_out_id;
    assign o_entry_count  = r_out_cnt;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("entry count beyond capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && i_cmd.res_sel == RES_CLEAR) |=> (r_count == '0))
        else $error("clear left entries");

    a_save_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && i_cmd.res_sel == RES_SAVE)
            |=> (r_count == $past(r_count) + IDX_W'(1)))
        else $error("save did not grow the table");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> out_free)
        else $error("result overwritten before it was taken");

endmodule

// ===== design/card_id_whitelist_table.sv =====
// Top level of the card ID whitelist table.
// A dense ordered table of up to 63 card IDs held in a single-port-read,
// single-port-write RAM, plus an entry count. One request is worked on at a
// time: check and save scan the stored IDs one per cycle, stopping early on a
// match; delete moves the later entries down one per cycle; read, clear, a
// save into a full table and the unused opcodes need no scan. The scan speed
// is set by the one RAM read port. A finished result sits in an output
// register, so the next request is taken while it waits. The RAM holds no
// reset value; only entries below the count are ever read.
module card_id_whitelist_table
    import cidw_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // card_id[31:0], entry_index[37:32], zero pad
    input  logic [2:0]  i_s_axis_tuser,   // opcode[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // result_index[5:0], card_id_out[37:6],
                                          // entry_count[43:38], zero pad
);

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [IDX_W-1:0] result_index;
    logic [ID_W-1:0]  card_id_out;
    logic [IDX_W-1:0] entry_count;

    cidw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    cidw_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_s_axis_tuser),
        .i_card_id      (i_s_axis_tdata[31:0]),
        .i_entry_index  (i_s_axis_tdata[37:32]),
        .i_out_ready    (i_m_axis_tready),
        .o_sts          (sts),
        .o_out_valid    (o_m_axis_tvalid),
        .o_result_index (result_index),
        .o_card_id_out  (card_id_out),
        .o_entry_count  (entry_count)
    );

    assign o_m_axis_tdata = {4'b0, entry_count, card_id_out, result_index};

endmodule

// ===== tb/testbench.sv =====
// Testbench for the card ID whitelist table: stream driver, reply checker and table predictor.
`timescale 1ns / 1ps

module testbench;
    import cidw_pkg::*;

    // opcodes with no operation behind them
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam int PHASE_ITEMS = 450;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS = 100;

    // result_index lowest, then card_id_out, then entry_count
    typedef struct packed {
        logic [IDX_W-1:0] entry_count;
        logic [ID_W-1:0]  card_id_out;
        logic [IDX_W-1:0] result_index;
    } t_table_reply;

    class table_scoreboard;
        logic [ID_W-1:0]  ids [STORE_DEPTH];
        logic [IDX_W-1:0] count;
        t_table_reply     pending_replies [$];
        int               errors;

        function new();
            count = '0;
            errors = 0;
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("%0t: reply mismatch: %s", $time, msg);
            errors++;
        endtask

        function logic [IDX_W-1:0] find_id(logic [ID_W-1:0] id);
            for (int i = 0; i < count; i++) begin
                if (ids[i] == id)
                    return IDX_W'(i + 1);
            end
            return '0;
        endfunction

        // Apply one accepted request to the shadow table and queue its reply.
        function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [IDX_W-1:0] idx);
            t_table_reply r;
            r = '0;
            case (op)
                OP_CHECK: r.result_index = find_id(id);
                OP_SAVE: begin
                    if (count < DEF_MAX_ENTRIES && find_id(id) == 0) begin
                        ids[count] = id;
                        count++;
                        r.result_index = count;
                    end
                end
                OP_READ: begin
                    if (idx != 0 && idx <= count) begin
                        r.card_id_out = ids[idx-1];
                        r.result_index = idx;
                    end
                end
                OP_DELETE: begin
                    if (idx != 0 && idx <= count) begin
                        for (int i = idx; i < count; i++)
                            ids[i-1] = ids[i];
                        count--;
                        r.result_index = idx;
                    end
                end
                OP_CLEAR: count = '0;
                default: ;
            endcase
            r.entry_count = count;
            pending_replies.push_back(r);
        endfunction

        task check_result(logic [47:0] data);
            t_table_reply got, want;
            got = t_table_reply'(data[43:0]);
            if (pending_replies.size() == 0) begin
                report($sformatf("reply %h with no request outstanding", data));
                return;
            end
            want = pending_replies.pop_front();
            if (got.result_index != want.result_index)
                report($sformatf("result_index %0d, want %0d",
                                 got.result_index, want.result_index));
            if (got.card_id_out != want.card_id_out)
                report($sformatf("card_id_out %h, want %h",
                                 got.card_id_out, want.card_id_out));
            if (got.entry_count != want.entry_count)
                report($sformatf("entry_count %0d, want %0d",
                                 got.entry_count, want.entry_count));
        endtask
    endclass

    logic        i_clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    table_scoreboard sb = new();

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_left;
    int fill_target;

    card_id_whitelist_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off counted down here
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Entered and left at a falling edge.
    task automatic issue_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                 logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx, id};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(op, id, idx);
        @(negedge i_clk);
    endtask

    // Saves and deletes lean towards a moving fill level so the table
    // regularly runs full and empty.
    task automatic issue_random_request();
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] idx;
        int r, save_w, del_w;
        id  = $urandom();
        idx = IDX_W'($urandom_range(63));
        r   = $urandom_range(99);
        save_w = (sb.count < fill_target) ? 55 : (sb.count > fill_target) ? 10 : 25;
        del_w  = (sb.count > fill_target) ? 45 : 10;
        if (r < 1) begin
            op = OP_CLEAR;
        end else if (r < 3) begin
            op = OP_RSVD_5 + OP_W'($urandom_range(2));
        end else begin
            r = $urandom_range(99);
            if (r < save_w) begin
                op = OP_SAVE;
                if (sb.count != 0 && $urandom_range(3) == 0)
                    id = sb.ids[$urandom_range(sb.count - 1)];
            end else if (r < save_w + del_w) begin
                op = OP_DELETE;
                if (sb.count != 0 && $urandom_range(4) != 0)
                    idx = IDX_W'($urandom_range(sb.count, 1));
            end else if (r[0]) begin
                op = OP_CHECK;
                if (sb.count != 0 && $urandom_range(4) < 3)
                    id = sb.ids[$urandom_range(sb.count - 1)];
            end else begin
                op = OP_READ;
                if (sb.count != 0 && $urandom_range(9) < 7)
                    idx = IDX_W'($urandom_range(sb.count, 1));
            end
        end
        issue_request(op, id, idx);
    endtask

    initial begin
        int phase_tx [4];
        int phase_rx [4];
        phase_tx = '{0, 79, 0, 18};
        phase_rx = '{0, 0, 79, 18};
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_left    = 0;
        fill_target  = 63;
        repeat (3) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, edge IDs, duplicates, bad indexes, unused opcodes
        issue_request(OP_CHECK,  32'h0000_0000, 6'd0);
        issue_request(OP_READ,   32'hFFFF_FFFF, 6'd1);
        issue_request(OP_DELETE, 32'h1234_5678, 6'd1);
        issue_request(OP_SAVE,   32'h0000_0000, 6'd63);
        issue_request(OP_SAVE,   32'hFFFF_FFFF, 6'd0);
        issue_request(OP_SAVE,   32'hFFFF_FFFF, 6'd5);
        issue_request(OP_SAVE,   32'hA5C3_0F96, 6'd0);
        issue_request(OP_CHECK,  32'hFFFF_FFFF, 6'd63);
        issue_request(OP_CHECK,  32'h1234_5678, 6'd2);
        issue_request(OP_READ,   32'hFFFF_FFFF, 6'd0);
        issue_request(OP_READ,   32'h0000_0000, 6'd3);
        issue_request(OP_READ,   32'h0000_0000, 6'd4);
        issue_request(OP_READ,   32'h0000_0000, 6'd63);
        issue_request(OP_DELETE, 32'hFFFF_FFFF, 6'd0);
        issue_request(OP_DELETE, 32'hFFFF_FFFF, 6'd63);
        issue_request(OP_DELETE, 32'h0000_0000, 6'd1);
        issue_request(OP_READ,   32'h0000_0000, 6'd1);
        issue_request(OP_RSVD_5, 32'hFFFF_FFFF, 6'd1);
        issue_request(OP_RSVD_6, 32'h0000_0000, 6'd2);
        issue_request(OP_RSVD_7, 32'hDEAD_BEEF, 6'd63);
        issue_request(OP_CLEAR,  32'hFFFF_FFFF, 6'd63);
        issue_request(OP_CHECK,  32'h0000_0000, 6'd0);
        issue_request(OP_SAVE,   32'h5A5A_5A5A, 6'd0);
        issue_request(OP_DELETE, 32'h0000_0000, 6'd1);

        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = phase_tx[p];
            rx_stall_pct = phase_rx[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    case ($urandom_range(9))
                        0, 1, 2: fill_target = 63;
                        3, 4:    fill_target = 0;
                        default: fill_target = $urandom_range(63);
                    endcase
                end
                issue_random_request();
            end
        end

        // long receiver hold-off while requests keep coming: input must back up
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_left    = 400;
        repeat (60) issue_random_request();

        s_tvalid <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
